>>> rtl/core/decimal_text_delta_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text delta formatter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_DELTA_FORMATTER_ASSERT_SVH
`define DECIMAL_TEXT_DELTA_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

`define DTDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtdf assertion failed");

`define DTDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtdf assertion failed");

`else

`define DTDF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define DTDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/dtdf_pkg.sv
// ----------------------------------------------------------------------------
// Decimal text delta formatter package
// Shared widths, character codes and the controller state type.
// ----------------------------------------------------------------------------
package dtdf_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 16;
    localparam int WIDTH_BITS  = 5;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_BITS    = 4 * BCD_DIGITS;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(6);

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT,
        ST_ERR,
        ST_HALT
    } t_state;

endpackage

>>> rtl/core/decimal_text_delta_formatter.sv
// ----------------------------------------------------------------------------
// Decimal text delta formatter
// Parses decimal numbers from a byte stream and prints their differences.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall) carries one text byte or an end of
// stream mark per transaction. The output channel (o_valid, i_stall) carries
// one character per transaction, or one error transaction with the line,
// value and prior of a decreasing number. The configuration channel
// (i_cfg_valid, o_cfg_ready) writes the printed digit width at any time the
// block is idle; o_cfg_ready is always high.
// Bytes that do not end a printed number are taken one per cycle. When a
// number ends and a difference is due, a bit-serial binary to decimal shifter
// runs, then digit_width digits (held to 1 to 16) and a newline leave the
// output register one per cycle while the receiver does not stall. The next
// byte is taken once the newline is in the output register. An error passes
// from the error state into the output register, and the block then accepts
// and drops every byte until reset.
// Reset clears the parser, sets digit_width to 6 and empties the output
// register. A stalled receiver holds the output register and, in turn, the
// digit sequencer; the input is not taken while digits are pending.
// ----------------------------------------------------------------------------
`include "decimal_text_delta_formatter_assert.svh"

module decimal_text_delta_formatter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_text_byte,
    input  logic                                 i_end_of_stream,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dtdf_pkg::WIDTH_BITS-1:0]      i_digit_width,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [7:0]                           o_out_char,
    output logic                                 o_is_last,
    output logic                                 o_error,
    output logic [31:0]                          o_error_line,
    output logic [31:0]                          o_error_value,
    output logic [31:0]                          o_error_prior
);

    import dtdf_pkg::*;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic [VALUE_BITS-1:0]   r_prev, n_prev;
    logic                    r_have_prev, n_have_prev;
    logic                    r_in_num, n_in_num;
    logic                    r_in_cmt, n_in_cmt;
    logic [31:0]             r_line, n_line;
    logic [WIDTH_BITS-1:0]   r_width_cfg;
    logic [WIDTH_BITS-1:0]   r_width, n_width;
    logic [VALUE_BITS-1:0]   r_bin, n_bin;
    logic [BCD_BITS-1:0]     r_bcd, n_bcd;
    logic [CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [WIDTH_BITS-1:0]   r_idx, n_idx;
    logic                    r_out_valid, n_out_valid;
    logic [7:0]              r_out_char, n_out_char;
    logic                    r_out_last, n_out_last;
    logic                    r_out_err, n_out_err;
    logic [31:0]             r_out_eline, n_out_eline;
    logic [31:0]             r_out_evalue, n_out_evalue;
    logic [31:0]             r_out_eprior, n_out_eprior;

    logic                    out_free;
    logic                    is_digit;
    logic [3:0]              digit_val;
    logic                    finish;
    logic                    bad;
    logic                    emit;
    logic [WIDTH_BITS-1:0]   width_clamped;
    logic [VALUE_BITS-1:0]   acc_next;
    logic [WIDTH_BITS-1:0]   sel_idx;
    logic [3:0]              sel_digit;
    logic [BCD_BITS-1:0]     bcd_adj;

    assign out_free  = !r_out_valid || !i_stall;
    assign is_digit  = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign digit_val = 4'(i_text_byte - CH_ZERO);
    assign finish    = r_in_num && (i_end_of_stream || !is_digit);
    assign bad       = finish && r_have_prev && (r_acc < r_prev);
    assign emit      = finish && r_have_prev && !bad;
    assign acc_next  = {r_acc[VALUE_BITS-4:0], 3'b000} + {r_acc[VALUE_BITS-2:0], 1'b0}
                     + VALUE_BITS'(digit_val);

    always_comb begin
        if (r_width_cfg == '0) begin
            width_clamped = WIDTH_BITS'(1);
        end else if (r_width_cfg > WIDTH_BITS'(MAX_DIGITS)) begin
            width_clamped = WIDTH_BITS'(MAX_DIGITS);
        end else begin
            width_clamped = r_width_cfg;
        end
    end

    always_comb begin
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (r_bcd[4*j +: 4] >= 4'd5) begin
                bcd_adj[4*j +: 4] = r_bcd[4*j +: 4] + 4'd3;
            end else begin
                bcd_adj[4*j +: 4] = r_bcd[4*j +: 4];
            end
        end
    end

    assign sel_idx = r_idx - WIDTH_BITS'(1);

    always_comb begin
        sel_digit = 4'd0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (sel_idx == WIDTH_BITS'(j)) begin
                sel_digit = r_bcd[4*j +: 4];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_in_num     = r_in_num;
        n_in_cmt     = r_in_cmt;
        n_line       = r_line;
        n_width      = r_width;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_stall;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        n_out_eline  = r_out_eline;
        n_out_evalue = r_out_evalue;
        n_out_eprior = r_out_eprior;
        o_stall      = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (bad) begin
                        n_state = ST_ERR;
                    end else if (i_end_of_stream) begin
                        n_acc       = '0;
                        n_prev      = '0;
                        n_have_prev = 1'b0;
                        n_in_num    = 1'b0;
                        n_in_cmt    = 1'b0;
                        n_line      = 32'd1;
                    end else if (r_in_num && is_digit) begin
                        n_acc = acc_next;
                    end else begin
                        if (finish) begin
                            n_in_num    = 1'b0;
                            n_prev      = r_acc;
                            n_have_prev = 1'b1;
                        end
                        if (r_in_cmt) begin
                            if (i_text_byte == CH_NEWLINE) begin
                                n_in_cmt = 1'b0;
                                n_line   = r_line + 32'd1;
                            end
                        end else if (is_digit) begin
                            n_in_num = 1'b1;
                            n_acc    = VALUE_BITS'(digit_val);
                        end else if (i_text_byte == CH_NEWLINE) begin
                            n_line = r_line + 32'd1;
                        end else if (i_text_byte == CH_HASH || i_text_byte == CH_SEMI) begin
                            n_in_cmt = 1'b1;
                        end
                    end
                    if (emit) begin
                        n_state = ST_CONV;
                        n_bin   = r_acc - r_prev;
                        n_bcd   = '0;
                        n_cnt   = '0;
                        n_width = width_clamped;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(VALUE_BITS - 1)) begin
                    n_state = ST_EMIT;
                    n_idx   = r_width;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_err    = 1'b0;
                    n_out_eline  = '0;
                    n_out_evalue = '0;
                    n_out_eprior = '0;
                    if (r_idx != '0) begin
                        n_out_char = CH_ZERO + {4'd0, sel_digit};
                        n_out_last = 1'b0;
                        n_idx      = sel_idx;
                    end else begin
                        n_out_char = CH_NEWLINE;
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = 8'd0;
                    n_out_last   = 1'b1;
                    n_out_err    = 1'b1;
                    n_out_eline  = r_line;
                    n_out_evalue = r_acc;
                    n_out_eprior = r_prev;
                    n_state      = ST_HALT;
                end
            end
            ST_HALT: begin
                o_stall = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_in_num    <= 1'b0;
            r_in_cmt    <= 1'b0;
            r_line      <= 32'd1;
            r_width_cfg <= WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_in_num    <= n_in_num;
            r_in_cmt    <= n_in_cmt;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_width_cfg <= i_digit_width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_width      <= n_width;
        r_bin        <= n_bin;
        r_bcd        <= n_bcd;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_err    <= n_out_err;
        r_out_eline  <= n_out_eline;
        r_out_evalue <= n_out_evalue;
        r_out_eprior <= n_out_eprior;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_is_last     = r_out_last;
    assign o_error       = r_out_err;
    assign o_error_line  = r_out_eline;
    assign o_error_value = r_out_evalue;
    assign o_error_prior = r_out_eprior;

    // An error transaction is always the final one for its byte.
    `DTDF_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_valid && o_error, o_is_last)

    // A difference always closes with a newline.
    `DTDF_ASSERT_IMP(a_last_newline, i_clk, i_rst_n,
        o_valid && o_is_last && !o_error, o_out_char == CH_NEWLINE)

    // Once halted, the block stays halted until reset.
    `DTDF_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_state == ST_HALT, r_state == ST_HALT)

    // The digit sequencer never runs while input bytes are being taken.
    `DTDF_ASSERT_IMP(a_emit_stalls, i_clk, i_rst_n,
        r_state == ST_CONV || r_state == ST_EMIT || r_state == ST_ERR, o_stall)

endmodule
